@@ sv/alc_pkg.sv @@
// Shared types, codes and defaults for the agglomerative linkage clustering block.
package alc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DIST_WIDTH_DEF = 32;

  localparam int ID_W       = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int METHOD_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD      = 1'd1;

  localparam logic [METHOD_W-1:0] METH_SINGLE   = 2'd0;
  localparam logic [METHOD_W-1:0] METH_COMPLETE = 2'd1;
  localparam logic [METHOD_W-1:0] METH_AVERAGE  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT,
    ST_ROW,
    ST_REBUILD
  } phase_t;

  typedef struct packed {
    phase_t phase;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic last;
  } ctl_sts_t;

endpackage

@@ sv/alc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module alc_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      num_r  <= '0;
      rem_r  <= '0;
      den_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
        num_r <= {num_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

@@ sv/alc_ctrl.sv @@
// Phase sequencer for loading and merging.
module alc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  alc_pkg::ctl_sts_t sts,
  output alc_pkg::ctl_cmd_t cmd,
  output logic              in_stall
);

  alc_pkg::phase_t state_r;
  alc_pkg::phase_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (sts.done) begin
      case (state_r)
        alc_pkg::ST_LOAD:    state_nxt = alc_pkg::ST_INIT;
        alc_pkg::ST_INIT:    state_nxt = alc_pkg::ST_SCAN;
        alc_pkg::ST_SCAN:    state_nxt = alc_pkg::ST_FETCH;
        alc_pkg::ST_FETCH:   state_nxt = alc_pkg::ST_EMIT;
        alc_pkg::ST_EMIT:    state_nxt = sts.last ? alc_pkg::ST_LOAD : alc_pkg::ST_ROW;
        alc_pkg::ST_ROW:     state_nxt = alc_pkg::ST_REBUILD;
        alc_pkg::ST_REBUILD: state_nxt = alc_pkg::ST_SCAN;
        default:             state_nxt = alc_pkg::ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd.phase = state_r;
    in_stall  = (state_r != alc_pkg::ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alc_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/alc_dp.sv @@
// Distance storage, scan, linkage update and result register.
module alc_dp #(
  parameter int MAX_POINTS = alc_pkg::MAX_POINTS_DEF,
  parameter int DIST_WIDTH = alc_pkg::DIST_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  alc_pkg::ctl_cmd_t              cmd,
  output alc_pkg::ctl_sts_t              sts,
  input  logic                           in_valid,
  input  logic [DIST_WIDTH-1:0]          in_distance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [alc_pkg::ID_W-1:0]       out_left_id,
  output logic [alc_pkg::ID_W-1:0]       out_right_id,
  output logic [DIST_WIDTH-1:0]          out_merge_distance,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW         = DIST_WIDTH;
  localparam int IW         = alc_pkg::ID_W;
  localparam int PW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int PAIR_DEPTH = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int AW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int TW         = $clog2(PAIR_DEPTH + 1);
  localparam int MW         = PW + CW + 1;
  localparam int PRW        = DW + CW;
  localparam int NUMW       = DW + CW + 1;

  // condensed address of pair (a,b), a<b, for np clusters
  function automatic logic [AW-1:0] tri_addr(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                             input logic [CW-1:0] np);
    logic [MW-1:0] m;
    logic [MW-1:0] prod;
    logic [MW-1:0] sum;
    m    = MW'({np, 1'b0}) - MW'(a) - MW'(1);
    prod = MW'(a) * m;
    sum  = (prod >> 1) + MW'(b) - MW'(a) - MW'(1);
    return AW'(sum);
  endfunction

  function automatic logic [AW-1:0] pair_addr(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                              input logic [CW-1:0] np);
    return (a < b) ? tri_addr(a, b, np) : tri_addr(b, a, np);
  endfunction

  // old list position of new position t, skipping the merged pair lo<hi
  function automatic logic [PW-1:0] pos_of(input logic [PW-1:0] t, input logic [PW-1:0] lo,
                                           input logic [PW-1:0] hi);
    logic [PW:0] t1;
    t1 = {1'b0, t} + (PW+1)'(1);
    if (t < lo) return t;
    if (t1 < {1'b0, hi}) return PW'(t1);
    return PW'(t1 + (PW+1)'(1));
  endfunction

  // storage
  logic [DW-1:0] pm_mem [PAIR_DEPTH];
  logic [IW-1:0] id_mem [MAX_POINTS];
  logic [CW-1:0] sz_mem [MAX_POINTS];
  logic [DW-1:0] nr_mem [MAX_POINTS];

  logic          pm_we;
  logic [AW-1:0] pm_waddr;
  logic [DW-1:0] pm_wdata;
  logic [AW-1:0] pm_raddr;
  logic [DW-1:0] pm_rd_r;
  logic          ix_we;
  logic [PW-1:0] ix_waddr;
  logic [PW-1:0] ix_raddr;
  logic [IW-1:0] id_wdata;
  logic [CW-1:0] sz_wdata;
  logic [IW-1:0] id_rd_r;
  logic [CW-1:0] sz_rd_r;
  logic          nr_we;
  logic [PW-1:0] nr_raddr;
  logic [DW-1:0] nr_wdata;
  logic [DW-1:0] nr_rd_r;

  // configuration
  logic [alc_pkg::CFG_DATA_W-1:0] pc_r;
  logic [alc_pkg::METHOD_W-1:0]   meth_r;
  logic [8:0]                     pc_ext;
  logic [CW-1:0]                  n_cfg;
  logic [2*CW-1:0]                tot_prod;
  logic [TW-1:0]                  total_cfg;

  // run state
  logic [TW-1:0] load_cnt_r;
  logic [TW-1:0] ld_idx;
  logic          ld_last;
  logic          accept;
  logic [CW-1:0] n_r;
  logic [CW-1:0] np_r;
  logic [PW-1:0] k_r;
  logic [2:0]    stp_r;
  logic [PW-1:0] n_m1;
  logic [PW-1:0] np_m1;
  logic [PW-1:0] np_m2;
  logic [PW-1:0] np_m3;

  // scan
  logic [PW-1:0] si_r;
  logic [PW-1:0] sj_r;
  logic [AW-1:0] sidx_r;
  logic          srun_r;
  logic          sv_r;
  logic [PW-1:0] svi_r;
  logic [PW-1:0] svj_r;
  logic          first_r;
  logic [DW-1:0] best_r;
  logic [PW-1:0] mini_r;
  logic [PW-1:0] minj_r;

  // merge
  logic [IW-1:0]  lid_r;
  logic [IW-1:0]  rid_r;
  logic [CW-1:0]  rc_r;
  logic [CW-1:0]  sc_r;
  logic [PW-1:0]  rx_r;
  logic [PW-1:0]  rt_r;
  logic [DW-1:0]  drx_r;
  logic [DW-1:0]  dsx_r;
  logic [IW-1:0]  xid_r;
  logic [CW-1:0]  xsz_r;
  logic [PRW-1:0] pa_r;
  logic [PRW-1:0] pb_r;
  logic [DW-1:0]  res_r;
  logic           avg;
  logic           row_go;
  logic           div_start;
  logic           div_done;
  logic [NUMW-1:0] div_quo;
  logic [PW-1:0]  bi_r;
  logic [PW-1:0]  bj_r;
  logic [AW-1:0]  bdst_r;
  logic           rb_newcol;
  logic           rb_end;

  // result register
  logic           out_valid_r;
  logic [IW-1:0]  out_lid_r;
  logic [IW-1:0]  out_rid_r;
  logic [DW-1:0]  out_dist_r;
  logic           out_last_r;
  logic           out_free;

  assign pc_ext = {2'b00, pc_r};
  always_comb begin
    if (pc_ext < 9'd2) begin
      n_cfg = CW'(2);
    end else if (pc_ext > 9'(MAX_POINTS)) begin
      n_cfg = CW'(MAX_POINTS);
    end else begin
      n_cfg = CW'(pc_ext);
    end
  end
  assign tot_prod  = (2*CW)'(n_cfg) * (2*CW)'(n_cfg - CW'(1));
  assign total_cfg = TW'(tot_prod >> 1);

  assign accept  = in_valid && (cmd.phase == alc_pkg::ST_LOAD);
  assign ld_idx  = (load_cnt_r >= total_cfg) ? '0 : load_cnt_r;
  assign ld_last = ({1'b0, ld_idx} + (TW+1)'(1)) == {1'b0, total_cfg};

  assign n_m1  = PW'(n_r - CW'(1));
  assign np_m1 = PW'(np_r - CW'(1));
  assign np_m2 = PW'(np_r - CW'(2));
  assign np_m3 = PW'(np_r - CW'(3));

  assign avg       = (meth_r == alc_pkg::METH_AVERAGE);
  assign row_go    = !avg || div_done;
  assign out_free  = !out_valid_r || !out_stall;
  assign rb_newcol = (bj_r == np_m2);
  assign rb_end    = rb_newcol && (bi_r == np_m3);
  assign nr_wdata  = avg ? DW'(div_quo) : res_r;

  alc_div #(
    .NUM_W(NUMW),
    .DEN_W(CW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (NUMW'(pa_r) + NUMW'(pb_r)),
    .den  (rc_r + sc_r),
    .done (div_done),
    .quo  (div_quo)
  );

  // memory ports and phase completion
  always_comb begin
    pm_we     = 1'b0;
    pm_waddr  = '0;
    pm_wdata  = '0;
    pm_raddr  = '0;
    ix_we     = 1'b0;
    ix_waddr  = '0;
    ix_raddr  = '0;
    id_wdata  = '0;
    sz_wdata  = '0;
    nr_we     = 1'b0;
    nr_raddr  = '0;
    div_start = 1'b0;
    sts.done  = 1'b0;
    sts.last  = (np_r == CW'(2));
    case (cmd.phase)
      alc_pkg::ST_LOAD: begin
        pm_we    = accept;
        pm_waddr = AW'(ld_idx);
        pm_wdata = in_distance;
        sts.done = accept && ld_last;
      end
      alc_pkg::ST_INIT: begin
        ix_we    = 1'b1;
        ix_waddr = rx_r;
        id_wdata = IW'(rx_r);
        sz_wdata = CW'(1);
        sts.done = (rx_r == n_m1);
      end
      alc_pkg::ST_SCAN: begin
        pm_raddr = sidx_r;
        sts.done = (stp_r == 3'd1) && !srun_r && sv_r;
      end
      alc_pkg::ST_FETCH: begin
        ix_raddr = (stp_r == 3'd0) ? mini_r : minj_r;
        sts.done = (stp_r == 3'd2);
      end
      alc_pkg::ST_EMIT: begin
        sts.done = out_free;
      end
      alc_pkg::ST_ROW: begin
        case (stp_r)
          3'd0: begin
            pm_raddr = pair_addr(mini_r, rx_r, np_r);
            ix_raddr = rx_r;
          end
          3'd1: pm_raddr = pair_addr(minj_r, rx_r, np_r);
          3'd4: div_start = avg;
          3'd5: begin
            nr_we    = row_go;
            ix_we    = row_go;
            ix_waddr = rt_r;
            id_wdata = xid_r;
            sz_wdata = xsz_r;
          end
          3'd6: begin
            ix_we    = 1'b1;
            ix_waddr = np_m2;
            id_wdata = IW'(n_r + CW'(k_r));
            sz_wdata = rc_r + sc_r;
            sts.done = 1'b1;
          end
          default: ;
        endcase
      end
      alc_pkg::ST_REBUILD: begin
        nr_raddr = bi_r;
        pm_raddr = tri_addr(pos_of(bi_r, mini_r, minj_r), pos_of(bj_r, mini_r, minj_r), np_r);
        if (stp_r == 3'd1) begin
          pm_we    = 1'b1;
          pm_waddr = bdst_r;
          pm_wdata = rb_newcol ? nr_rd_r : pm_rd_r;
          sts.done = rb_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    pm_rd_r <= pm_mem[pm_raddr];
    if (ix_we) begin
      id_mem[ix_waddr] <= id_wdata;
      sz_mem[ix_waddr] <= sz_wdata;
    end
    id_rd_r <= id_mem[ix_raddr];
    sz_rd_r <= sz_mem[ix_raddr];
    if (nr_we) nr_mem[rt_r] <= nr_wdata;
    nr_rd_r <= nr_mem[nr_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= alc_pkg::CFG_DATA_W'(2);
      meth_r      <= alc_pkg::METH_SINGLE;
      load_cnt_r  <= '0;
      n_r         <= CW'(2);
      np_r        <= CW'(2);
      k_r         <= '0;
      stp_r       <= '0;
      si_r        <= '0;
      sj_r        <= '0;
      sidx_r      <= '0;
      srun_r      <= 1'b0;
      sv_r        <= 1'b0;
      svi_r       <= '0;
      svj_r       <= '0;
      first_r     <= 1'b0;
      best_r      <= '0;
      mini_r      <= '0;
      minj_r      <= '0;
      lid_r       <= '0;
      rid_r       <= '0;
      rc_r        <= '0;
      sc_r        <= '0;
      rx_r        <= '0;
      rt_r        <= '0;
      drx_r       <= '0;
      dsx_r       <= '0;
      xid_r       <= '0;
      xsz_r       <= '0;
      pa_r        <= '0;
      pb_r        <= '0;
      res_r       <= '0;
      bi_r        <= '0;
      bj_r        <= '0;
      bdst_r      <= '0;
      out_valid_r <= 1'b0;
      out_lid_r   <= '0;
      out_rid_r   <= '0;
      out_dist_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.phase)
        alc_pkg::ST_LOAD: begin
          if (accept) begin
            load_cnt_r <= ld_last ? '0 : ld_idx + TW'(1);
            if (ld_last) begin
              n_r  <= n_cfg;
              np_r <= n_cfg;
              k_r  <= '0;
              rx_r <= '0;
            end
          end
        end
        alc_pkg::ST_INIT: begin
          rx_r  <= rx_r + PW'(1);
          stp_r <= '0;
        end
        alc_pkg::ST_SCAN: begin
          if (stp_r == 3'd0) begin
            si_r    <= '0;
            sj_r    <= PW'(1);
            sidx_r  <= '0;
            srun_r  <= 1'b1;
            first_r <= 1'b1;
            sv_r    <= 1'b0;
            stp_r   <= 3'd1;
          end else begin
            sv_r  <= srun_r;
            svi_r <= si_r;
            svj_r <= sj_r;
            if (srun_r) begin
              sidx_r <= sidx_r + AW'(1);
              if (sj_r == np_m1) begin
                if (si_r == np_m2) begin
                  srun_r <= 1'b0;
                end else begin
                  si_r <= si_r + PW'(1);
                  sj_r <= si_r + PW'(2);
                end
              end else begin
                sj_r <= sj_r + PW'(1);
              end
            end
            if (sv_r) begin
              first_r <= 1'b0;
              if (first_r || (pm_rd_r < best_r)) begin
                best_r <= pm_rd_r;
                mini_r <= svi_r;
                minj_r <= svj_r;
              end
            end
            if (!srun_r && sv_r) stp_r <= '0;
          end
        end
        alc_pkg::ST_FETCH: begin
          case (stp_r)
            3'd0: stp_r <= 3'd1;
            3'd1: begin
              lid_r <= id_rd_r;
              rc_r  <= sz_rd_r;
              stp_r <= 3'd2;
            end
            default: begin
              rid_r <= id_rd_r;
              sc_r  <= sz_rd_r;
              rx_r  <= '0;
              rt_r  <= '0;
              stp_r <= '0;
            end
          endcase
        end
        alc_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_lid_r   <= lid_r;
            out_rid_r   <= rid_r;
            out_dist_r  <= best_r;
            out_last_r  <= (np_r == CW'(2));
          end
        end
        alc_pkg::ST_ROW: begin
          case (stp_r)
            3'd0: begin
              if ((rx_r == mini_r) || (rx_r == minj_r)) begin
                if (rx_r == np_m1) begin
                  stp_r <= 3'd6;
                end else begin
                  rx_r <= rx_r + PW'(1);
                end
              end else begin
                stp_r <= 3'd1;
              end
            end
            3'd1: begin
              drx_r <= pm_rd_r;
              xid_r <= id_rd_r;
              xsz_r <= sz_rd_r;
              stp_r <= 3'd2;
            end
            3'd2: begin
              dsx_r <= pm_rd_r;
              stp_r <= 3'd3;
            end
            3'd3: begin
              pa_r  <= PRW'(drx_r) * PRW'(rc_r);
              pb_r  <= PRW'(dsx_r) * PRW'(sc_r);
              stp_r <= 3'd4;
            end
            3'd4: begin
              if (meth_r == alc_pkg::METH_COMPLETE) begin
                res_r <= (drx_r > dsx_r) ? drx_r : dsx_r;
              end else begin
                res_r <= (drx_r < dsx_r) ? drx_r : dsx_r;
              end
              stp_r <= 3'd5;
            end
            3'd5: begin
              if (row_go) begin
                rt_r <= rt_r + PW'(1);
                if (rx_r == np_m1) begin
                  stp_r <= 3'd6;
                end else begin
                  rx_r  <= rx_r + PW'(1);
                  stp_r <= 3'd0;
                end
              end
            end
            default: begin
              bi_r   <= '0;
              bj_r   <= PW'(1);
              bdst_r <= '0;
              stp_r  <= '0;
            end
          endcase
        end
        alc_pkg::ST_REBUILD: begin
          if (stp_r == 3'd0) begin
            stp_r <= 3'd1;
          end else begin
            stp_r  <= '0;
            bdst_r <= bdst_r + AW'(1);
            if (rb_newcol) begin
              if (rb_end) begin
                np_r <= np_r - CW'(1);
                k_r  <= k_r + PW'(1);
              end else begin
                bi_r <= bi_r + PW'(1);
                bj_r <= bi_r + PW'(2);
              end
            end else begin
              bj_r <= bj_r + PW'(1);
            end
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          alc_pkg::CFG_POINT_COUNT: begin
            pc_r       <= cfg_data;
            load_cnt_r <= '0;
          end
          alc_pkg::CFG_METHOD: meth_r <= cfg_data[alc_pkg::METHOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_id        = out_lid_r;
  assign out_right_id       = out_rid_r;
  assign out_merge_distance = out_dist_r;
  assign out_last           = out_last_r;

endmodule

@@ sv/agglomerative_linkage_clustering.sv @@
// Top level of the agglomerative linkage clustering block.
//
// Usage: write point_count (index 0) and method (index 1) on the cfg port
// while idle, then send the condensed upper-triangle distance matrix,
// row-major, one request per cycle on in_valid/in_stall. After the last
// request in_stall rises and the block runs n-1 merges, returning one
// request per merge on out_valid/out_stall with the two cluster ids, the
// merge distance and out_last on the final one. Each merge scans the
// np(np-1)/2 pairs of the np live clusters (one memory read each),
// computes a linkage row entry for every surviving cluster (with a divide
// for weighted average) and then rewrites the condensed distance memory
// pair by pair. A stalled result is held; the datapath keeps working
// and waits only when the next result is ready and the output register
// is still full. Reset (synchronous, rst_n low) returns to loading with
// point_count 2 and single linkage; memory contents are not cleared,
// every entry read in a run is written earlier in that run.
module agglomerative_linkage_clustering #(
  parameter int MAX_POINTS = alc_pkg::MAX_POINTS_DEF,
  parameter int DIST_WIDTH = alc_pkg::DIST_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [DIST_WIDTH-1:0]          in_distance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [alc_pkg::ID_W-1:0]       out_left_id,
  output logic [alc_pkg::ID_W-1:0]       out_right_id,
  output logic [DIST_WIDTH-1:0]          out_merge_distance,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data
);

  alc_pkg::ctl_cmd_t cmd;
  alc_pkg::ctl_sts_t sts;

  // phase sequencing
  alc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .sts     (sts),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  // storage, search, linkage arithmetic and result register
  alc_dp #(
    .MAX_POINTS(MAX_POINTS),
    .DIST_WIDTH(DIST_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_valid),
    .in_distance       (in_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_id       (out_left_id),
    .out_right_id      (out_right_id),
    .out_merge_distance(out_merge_distance),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule
